// ===== sv/rtpp_pkg.sv =====
`default_nettype none
package rtpp_pkg;

  localparam int FRAC = 30;
  localparam int DIV_BITS = 62;
  localparam int DIV_REM_W = 31;
  localparam int DIV_LAT = DIV_BITS + 1;
  localparam int QMUL_LAT = 4;

  localparam logic signed [31:0] RADIAL_K3_Q30 = 32'sd0;

  localparam logic signed [63:0] BIG = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
  localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF_0000;

  // Position of each step after the divider output; PIPE_LAT spans an accepted start to its done strobe.
  localparam int T_L1 = QMUL_LAT;
  localparam int T_R2 = T_L1 + 1;
  localparam int T_TX = T_R2 + 1;
  localparam int T_R4 = T_R2 + QMUL_LAT;
  localparam int T_RAD1 = T_R4 + 1;
  localparam int T_R6 = T_R4 + QMUL_LAT;
  localparam int T_RAD2 = T_R6 + 1;
  localparam int T_K3 = T_R6 + QMUL_LAT;
  localparam int T_RAD3 = T_K3 + 1;
  localparam int T_D1 = T_RAD3 + QMUL_LAT;
  localparam int T_D2 = T_D1 + 1;
  localparam int T_D3 = T_D2 + 1;
  localparam int T_UP = T_D3 + QMUL_LAT;
  localparam int T_OUT = T_UP + 1;
  localparam int PIPE_LAT = 1 + DIV_LAT + T_OUT;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_TANGENTIAL_P1,
    REG_TANGENTIAL_P2
  } cfg_reg_t;

  function automatic logic signed [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({BIG[63], BIG})) return BIG;
    if (s < -$signed({BIG[63], BIG})) return -BIG;
    return s[63:0];
  endfunction

  function automatic logic [31:0] to_out32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rtpp_div.sv =====
`default_nettype none
module rtpp_div import rtpp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic [31:0]          dividend_mag,
  input  wire logic [DIV_REM_W-1:0] divisor,
  input  wire logic                 neg,
  output logic signed [63:0]        quotient
);

  logic [DIV_REM_W-1:0] rem_r  [DIV_BITS];
  logic [DIV_BITS-1:0]  dq_r   [DIV_BITS];
  logic [DIV_REM_W-1:0] z_r    [DIV_BITS];
  logic                 neg_r  [DIV_BITS];
  logic [DIV_REM_W-1:0] rem_next [DIV_BITS];
  logic [DIV_BITS-1:0]  dq_next  [DIV_BITS];
  logic [DIV_REM_W-1:0] z_next   [DIV_BITS];
  logic                 neg_next [DIV_BITS];

  // One restoring step per stage: shift in a dividend bit, subtract if it fits.
  always_comb begin
    logic [DIV_REM_W-1:0] rem_in;
    logic [DIV_BITS-1:0]  dq_in;
    logic [DIV_REM_W:0]   trial;
    logic [DIV_REM_W:0]   diff;
    logic                 fits;
    for (int s = 0; s < DIV_BITS; s++) begin
      if (s == 0) begin
        rem_in = '0;
        dq_in = {dividend_mag, {(DIV_BITS - 32){1'b0}}};
        z_next[s] = divisor;
        neg_next[s] = neg;
      end else begin
        rem_in = rem_r[s-1];
        dq_in = dq_r[s-1];
        z_next[s] = z_r[s-1];
        neg_next[s] = neg_r[s-1];
      end
      trial = {rem_in, dq_in[DIV_BITS-1]};
      diff = trial - {1'b0, z_next[s]};
      fits = trial >= {1'b0, z_next[s]};
      rem_next[s] = fits ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
      dq_next[s] = {dq_in[DIV_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_BITS; s++) begin
      rem_r[s] <= rem_next[s];
      dq_r[s] <= dq_next[s];
      z_r[s] <= z_next[s];
      neg_r[s] <= neg_next[s];
    end
    quotient <= neg_r[DIV_BITS-1] ? -$signed({2'b00, dq_r[DIV_BITS-1]})
                                  : $signed({2'b00, dq_r[DIV_BITS-1]});
  end

endmodule
`default_nettype wire

// ===== sv/rtpp_qmul.sv =====
`default_nettype none
module rtpp_qmul import rtpp_pkg::*; (
  input  wire logic               clk,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  input  wire logic               sh29,
  output logic signed [63:0]      prod
);

  logic [63:0]  ua, ub;
  logic         neg1, neg2, neg3;
  logic         sh1, sh2, sh3;
  logic [63:0]  ll, lh, hl, hh;
  logic [127:0] full;
  logic [127:0] shifted;
  logic [63:0]  mag;

  always_comb begin
    shifted = sh3 ? (full >> (FRAC - 1)) : (full >> FRAC);
    mag = (shifted > {64'd0, BIG}) ? BIG : shifted[63:0];
  end

  // Magnitudes, then four 32x32 partial products, then the sum, then scale.
  always_ff @(posedge clk) begin
    ua <= a[63] ? 64'(-a) : 64'(a);
    ub <= b[63] ? 64'(-b) : 64'(b);
    neg1 <= a[63] ^ b[63];
    sh1 <= sh29;
    ll <= 64'(ua[31:0]) * 64'(ub[31:0]);
    lh <= 64'(ua[31:0]) * 64'(ub[63:32]);
    hl <= 64'(ua[63:32]) * 64'(ub[31:0]);
    hh <= 64'(ua[63:32]) * 64'(ub[63:32]);
    neg2 <= neg1;
    sh2 <= sh1;
    full <= {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
    neg3 <= neg2;
    sh3 <= sh2;
    prod <= neg3 ? -$signed(mag) : $signed(mag);
  end

endmodule
`default_nettype wire

// ===== sv/radial_tangential_point_projection.sv =====
// Brown-Conrady point projection, Q16.16 in and out.
// Input: pulse start with point_x, point_y, point_z; busy stays low, so a
// point can be taken every clock. Output: done is high for one cycle with
// pixel_u, pixel_v and in_front; the receiver must take it then.
// The pipeline accepts one point per clock sustained. Its depth is set by
// the 62-stage restoring divider that forms x/z and y/z, plus the chain
// of dependent multiplier units for the squares, r4, r6, the radial factor,
// the distorted point and the focal scale.
// Configuration: cfg_we, cfg_index, cfg_data write focal_x, focal_y,
// center_x, center_y, radial_k1, radial_k2, tangential_p1, tangential_p2
// in that index order; write only while no point is in flight.
// Reset (rst, synchronous) clears the configuration registers to zero and
// drops every point in flight. A point with non-positive depth gives -1.0
// for both coordinates and in_front low.
`default_nettype none
module radial_tangential_point_projection import rtpp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] point_x,
  input  wire logic [31:0] point_y,
  input  wire logic [31:0] point_z,
  output logic             done,
  output logic [31:0]      pixel_u,
  output logic [31:0]      pixel_v,
  output logic             in_front,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int NX_DLY = T_RAD3;
  localparam int XY_DLY = T_RAD3 - T_L1;
  localparam int TX_DLY = T_RAD3 - T_TX;
  localparam int R2_DLY = T_R4 - T_R2;
  localparam int RAD1_DLY = T_R6 - T_RAD1;
  localparam int RAD2_DLY = T_K3 - T_RAD2;

  logic [31:0] focal_x, focal_y, center_x, center_y;
  logic [31:0] radial_k1, radial_k2, tangential_p1, tangential_p2;

  logic vld [PIPE_LAT];
  logic fr  [PIPE_LAT];

  logic [31:0]          x_mag, y_mag;
  logic                 x_neg, y_neg;
  logic [DIV_REM_W-1:0] z_in;

  logic signed [63:0] nx, ny;
  logic signed [63:0] x2, y2, xy2, r4, k1r2, r6, k2r4, k3r6;
  logic signed [63:0] r2, x2x2, y2y2, tx, ty;
  logic signed [63:0] rad1, rad2, rad3;
  logic signed [63:0] dx1, dy1, xp1, yp2, p2tx, p1ty, p2tx_d, p1ty_d;
  logic signed [63:0] dx2, dy2, dx3, dy3, pu, pv;

  logic signed [63:0] nx_dl [NX_DLY];
  logic signed [63:0] ny_dl [NX_DLY];
  logic signed [63:0] xy_dl [XY_DLY];
  logic signed [63:0] tx_dl [TX_DLY];
  logic signed [63:0] ty_dl [TX_DLY];
  logic signed [63:0] r2_dl [R2_DLY];
  logic signed [63:0] rad1_dl [RAD1_DLY];
  logic signed [63:0] rad2_dl [RAD2_DLY];

  assign busy = 1'b0;
  assign done = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= '0;
      focal_y <= '0;
      center_x <= '0;
      center_y <= '0;
      radial_k1 <= '0;
      radial_k2 <= '0;
      tangential_p1 <= '0;
      tangential_p2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:       focal_x <= cfg_data;
        REG_FOCAL_Y:       focal_y <= cfg_data;
        REG_CENTER_X:      center_x <= cfg_data;
        REG_CENTER_Y:      center_y <= cfg_data;
        REG_RADIAL_K1:     radial_k1 <= cfg_data;
        REG_RADIAL_K2:     radial_k2 <= cfg_data;
        REG_TANGENTIAL_P1: tangential_p1 <= cfg_data;
        REG_TANGENTIAL_P2: tangential_p2 <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    fr[0] <= !point_z[31] && (point_z != 32'd0);
    for (int i = 1; i < PIPE_LAT; i++) fr[i] <= fr[i-1];
    x_mag <= point_x[31] ? (~point_x + 32'd1) : point_x;
    y_mag <= point_y[31] ? (~point_y + 32'd1) : point_y;
    x_neg <= point_x[31];
    y_neg <= point_y[31];
    z_in <= point_z[DIV_REM_W-1:0];
  end

  rtpp_div u_div_x (.clk, .dividend_mag(x_mag), .divisor(z_in), .neg(x_neg), .quotient(nx));
  rtpp_div u_div_y (.clk, .dividend_mag(y_mag), .divisor(z_in), .neg(y_neg), .quotient(ny));

  rtpp_qmul u_x2  (.clk, .a(nx), .b(nx), .sh29(1'b0), .prod(x2));
  rtpp_qmul u_y2  (.clk, .a(ny), .b(ny), .sh29(1'b0), .prod(y2));
  rtpp_qmul u_xy2 (.clk, .a(nx), .b(ny), .sh29(1'b1), .prod(xy2));

  rtpp_qmul u_r4   (.clk, .a(r2), .b(r2), .sh29(1'b0), .prod(r4));
  rtpp_qmul u_k1r2 (.clk, .a(sext32(radial_k1)), .b(r2), .sh29(1'b0), .prod(k1r2));
  rtpp_qmul u_r6   (.clk, .a(r2_dl[R2_DLY-1]), .b(r4), .sh29(1'b0), .prod(r6));
  rtpp_qmul u_k2r4 (.clk, .a(sext32(radial_k2)), .b(r4), .sh29(1'b0), .prod(k2r4));
  rtpp_qmul u_k3r6 (.clk, .a(sext32(RADIAL_K3_Q30)), .b(r6), .sh29(1'b0), .prod(k3r6));

  rtpp_qmul u_dx1 (.clk, .a(nx_dl[NX_DLY-1]), .b(rad3), .sh29(1'b0), .prod(dx1));
  rtpp_qmul u_dy1 (.clk, .a(ny_dl[NX_DLY-1]), .b(rad3), .sh29(1'b0), .prod(dy1));
  rtpp_qmul u_xp1 (.clk, .a(xy_dl[XY_DLY-1]), .b(sext32(tangential_p1)), .sh29(1'b0),
                   .prod(xp1));
  rtpp_qmul u_yp2 (.clk, .a(xy_dl[XY_DLY-1]), .b(sext32(tangential_p2)), .sh29(1'b0),
                   .prod(yp2));
  rtpp_qmul u_p2tx (.clk, .a(sext32(tangential_p2)), .b(tx_dl[TX_DLY-1]), .sh29(1'b0),
                    .prod(p2tx));
  rtpp_qmul u_p1ty (.clk, .a(sext32(tangential_p1)), .b(ty_dl[TX_DLY-1]), .sh29(1'b0),
                    .prod(p1ty));

  rtpp_qmul u_pu (.clk, .a({32'd0, focal_x}), .b(dx3), .sh29(1'b0), .prod(pu));
  rtpp_qmul u_pv (.clk, .a({32'd0, focal_y}), .b(dy3), .sh29(1'b0), .prod(pv));

  // Sums and alignment lines; every stage advances each cycle.
  always_ff @(posedge clk) begin
    r2 <= sat_add(x2, y2);
    x2x2 <= sat_add(x2, x2);
    y2y2 <= sat_add(y2, y2);
    tx <= sat_add(r2, x2x2);
    ty <= sat_add(r2, y2y2);
    rad1 <= sat_add(ONE_Q30, k1r2);
    rad2 <= sat_add(rad1_dl[RAD1_DLY-1], k2r4);
    rad3 <= sat_add(rad2_dl[RAD2_DLY-1], k3r6);
    dx2 <= sat_add(dx1, xp1);
    dy2 <= sat_add(dy1, yp2);
    p2tx_d <= p2tx;
    p1ty_d <= p1ty;
    dx3 <= sat_add(dx2, p2tx_d);
    dy3 <= sat_add(dy2, p1ty_d);

    nx_dl[0] <= nx;
    ny_dl[0] <= ny;
    for (int i = 1; i < NX_DLY; i++) begin
      nx_dl[i] <= nx_dl[i-1];
      ny_dl[i] <= ny_dl[i-1];
    end
    xy_dl[0] <= xy2;
    for (int i = 1; i < XY_DLY; i++) xy_dl[i] <= xy_dl[i-1];
    tx_dl[0] <= tx;
    ty_dl[0] <= ty;
    for (int i = 1; i < TX_DLY; i++) begin
      tx_dl[i] <= tx_dl[i-1];
      ty_dl[i] <= ty_dl[i-1];
    end
    r2_dl[0] <= r2;
    for (int i = 1; i < R2_DLY; i++) r2_dl[i] <= r2_dl[i-1];
    rad1_dl[0] <= rad1;
    for (int i = 1; i < RAD1_DLY; i++) rad1_dl[i] <= rad1_dl[i-1];
    rad2_dl[0] <= rad2;
    for (int i = 1; i < RAD2_DLY; i++) rad2_dl[i] <= rad2_dl[i-1];

    // Replace the result of a point behind the camera.
    if (fr[PIPE_LAT-2]) begin
      pixel_u <= to_out32(sat_add({32'd0, center_x}, pu));
      pixel_v <= to_out32(sat_add({32'd0, center_y}, pv));
      in_front <= 1'b1;
    end else begin
      pixel_u <= MINUS_ONE_Q16;
      pixel_v <= MINUS_ONE_Q16;
      in_front <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtpp_check.sv =====
`default_nettype none
module rtpp_check import rtpp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [31:0] point_z,
  input wire logic        done,
  input wire logic [31:0] pixel_u,
  input wire logic [31:0] pixel_v,
  input wire logic        in_front
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_LAT done)
    else $error("transaction lost in the pipeline");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transaction");

  a_front_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> in_front == $past(!point_z[31] && point_z != 32'd0, PIPE_LAT))
    else $error("in_front does not match the depth sign");

  a_behind: assert property (@(posedge clk) disable iff (rst)
    done && !in_front |-> pixel_u == MINUS_ONE_Q16 && pixel_v == MINUS_ONE_Q16)
    else $error("point behind camera must give -1.0");

endmodule

bind radial_tangential_point_projection rtpp_check u_rtpp_check (.*);
`default_nettype wire

// ===== bench/radial_tangential_point_projection_tb.sv =====
`default_nettype none
module radial_tangential_point_projection_tb import rtpp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic        front;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [31:0] point_z = '0;
  logic        done;
  logic [31:0] pixel_u;
  logic [31:0] pixel_v;
  logic        in_front;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_FOCAL_X;
  logic [31:0] cfg_data = '0;

  radial_tangential_point_projection uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .done(done), .pixel_u(pixel_u), .pixel_v(pixel_v), .in_front(in_front),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  class pixel_scoreboard;
    logic [31:0] regs [8];
    pixel_t      pending [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function automatic longint mul_q(longint a, longint b, int sh);
      logic [127:0]    p;
      longint unsigned ua, ub, q;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> sh;
      q = (p > 128'(SAT)) ? SAT : p[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint add_q(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SAT) return SAT;
      if (s < -SAT) return -SAT;
      return s;
    endfunction

    function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function automatic pixel_t project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint x, y, z, k1, k2, k3, p1, p2;
      longint nx, ny, x2, y2, r2, r4, r6, xy2, rad, dx, dy;
      pixel_t r;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      if (z <= 0) begin
        r.u = MINUS_ONE_Q16;
        r.v = MINUS_ONE_Q16;
        r.front = 1'b0;
        return r;
      end
      k1 = longint'($signed(regs[REG_RADIAL_K1]));
      k2 = longint'($signed(regs[REG_RADIAL_K2]));
      k3 = longint'(RADIAL_K3_Q30);
      p1 = longint'($signed(regs[REG_TANGENTIAL_P1]));
      p2 = longint'($signed(regs[REG_TANGENTIAL_P2]));
      nx = (x * (64'sd1 <<< FRAC)) / z;
      ny = (y * (64'sd1 <<< FRAC)) / z;
      x2 = mul_q(nx, nx, FRAC);
      y2 = mul_q(ny, ny, FRAC);
      r2 = add_q(x2, y2);
      r4 = mul_q(r2, r2, FRAC);
      r6 = mul_q(r2, r4, FRAC);
      xy2 = mul_q(nx, ny, FRAC - 1);
      rad = add_q(64'sd1 <<< FRAC, mul_q(k1, r2, FRAC));
      rad = add_q(rad, mul_q(k2, r4, FRAC));
      rad = add_q(rad, mul_q(k3, r6, FRAC));
      dx = mul_q(nx, rad, FRAC);
      dx = add_q(dx, mul_q(xy2, p1, FRAC));
      dx = add_q(dx, mul_q(p2, add_q(r2, add_q(x2, x2)), FRAC));
      dy = mul_q(ny, rad, FRAC);
      dy = add_q(dy, mul_q(xy2, p2, FRAC));
      dy = add_q(dy, mul_q(p1, add_q(r2, add_q(y2, y2)), FRAC));
      r.u = clip32(add_q(longint'({32'd0, regs[REG_CENTER_X]}),
                         mul_q(longint'({32'd0, regs[REG_FOCAL_X]}), dx, FRAC)));
      r.v = clip32(add_q(longint'({32'd0, regs[REG_CENTER_Y]}),
                         mul_q(longint'({32'd0, regs[REG_FOCAL_Y]}), dy, FRAC)));
      r.front = 1'b1;
      return r;
    endfunction

    function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      pending.push_back(project(px, py, pz));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report("unexpected transaction", got.u, '0);
        return;
      end
      want = pending.pop_front();
      if (got.u !== want.u) report("pixel_u", got.u, want.u);
      if (got.v !== want.v) report("pixel_v", got.v, want.v);
      if (got.front !== want.front) report("in_front", 32'(got.front), 32'(want.front));
    endtask
  endclass

  pixel_scoreboard sb = new();
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst && done) sb.check_pixel('{pixel_u, pixel_v, in_front});
  end

  task write_reg(cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.regs[idx] = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    start = 1'b1;
    point_x = px;
    point_y = py;
    point_z = pz;
    do @(posedge clk); while (busy);
    sb.note_point(px, py, pz);
  endtask

  // hold the line idle until every transaction has come back
  task drain();
    @(negedge clk);
    start = 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    logic [31:0] c;
    case ($urandom_range(0, 3))
      0: c = $urandom;
      default: c = $urandom_range(0, 1 << 27) - (1 << 26);
    endcase
    return c;
  endfunction

  task random_point();
    logic [31:0] zz, xx, yy;
    case ($urandom_range(0, 9))
      0, 1: send_point($urandom, $urandom, $urandom);
      2: send_point($urandom, $urandom, -$urandom_range(0, 1 << 20));
      default: begin
        zz = $urandom_range(1 << 12, 100 << 16);
        xx = $urandom_range(0, 2 * zz) - zz;
        yy = $urandom_range(0, 2 * zz) - zz;
        send_point(xx, yy, zz);
      end
    endcase
  endtask

  task directed_points();
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0004_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
  endtask

  task load_config(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx, logic [31:0] cy,
                   logic [31:0] k1, logic [31:0] k2, logic [31:0] p1, logic [31:0] p2);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIAL_K1, k1);
    write_reg(REG_RADIAL_K2, k2);
    write_reg(REG_TANGENTIAL_P1, p1);
    write_reg(REG_TANGENTIAL_P2, p2);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // all registers still at their reset value
    directed_points();
    repeat (20) random_point();
    drain();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: load_config(32'h0001_0000, 32'h0001_0000, '0, '0, '0, '0, '0, '0);
        1: load_config(500 << 16, 500 << 16, 320 << 16, 240 << 16,
                       32'hF800_0000, 32'h0100_0000, 32'h0010_0000, 32'hFFF0_0000);
        2: load_config('1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: load_config('1, '1, '0, '0, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000);
        default: load_config($urandom, $urandom, $urandom, $urandom,
                             rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      if (phase < 4) directed_points();
      repeat (70) random_point();
      drain();
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("radial_tangential_point_projection regression: pass");
    else
      $display("radial_tangential_point_projection regression: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("radial_tangential_point_projection regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
